// ===== sv/iel_pkg.sv =====
package iel_pkg;

    localparam int CAPACITY  = 64;
    localparam int ELEM_W    = 32;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 7;
    localparam int ST_W      = 2;

    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int IDX_SPAN  = 1 << IDX_W;
    localparam int NREAD     = (CAPACITY < IDX_SPAN) ? CAPACITY : IDX_SPAN;
    localparam int GRP       = 8;
    localparam int NGRP      = (NREAD + GRP - 1) / GRP;

    typedef logic [ELEM_W-1:0] t_elem;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_INS   = 2'd2,
        CMD_ERASE = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_REDUCE,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic             ins;
        logic             era;
        logic             wr;
        logic [CMP_W-1:0] idx;
        t_elem            val;
    } t_cell_ctrl;

    function automatic t_elem to_elem(input logic [VAL_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[ELEM_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] from_elem(input t_elem e);
        logic [63:0] t;
        t = 64'(e);
        return t[VAL_W-1:0];
    endfunction

endpackage

// ===== sv/iel_cmd_if.sv =====
interface iel_cmd_if import iel_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;

    modport source (output valid, command, index, value, input ready);
    modport sink   (input valid, command, index, value, output ready);
endinterface

// ===== sv/iel_res_if.sv =====
interface iel_res_if import iel_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VAL_W-1:0]     read_value;
    logic [CNT_OUT_W-1:0] element_count;
    logic [ST_W-1:0]      status;

    modport source (output valid, read_value, element_count, status, input ready);
    modport sink   (input valid, read_value, element_count, status, output ready);
endinterface

// ===== sv/iel_cell.sv =====
module iel_cell import iel_pkg::*; (
    input  logic             i_clk,
    input  logic [CMP_W-1:0] i_pos,
    input  t_cell_ctrl       i_ctrl,
    input  t_elem            i_left,
    input  t_elem            i_right,
    output t_elem            o_data
);

    t_elem r_data;
    t_elem n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.wr && (i_pos == i_ctrl.idx)) begin
            n_data = i_ctrl.val;
        end else if (i_ctrl.ins) begin
            if (i_pos == i_ctrl.idx) begin
                n_data = i_ctrl.val;
            end else if (i_pos > i_ctrl.idx) begin
                n_data = i_left;
            end
        end else if (i_ctrl.era && (i_pos >= i_ctrl.idx)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== sv/iel_read_tree.sv =====
module iel_read_tree import iel_pkg::*; (
    input  logic             i_clk,
    input  t_elem            i_data [NREAD],
    input  logic [IDX_W-1:0] i_idx,
    output t_elem            o_data
);

    t_elem r_grp [NGRP];
    t_elem n_grp [NGRP];
    t_elem r_out;
    t_elem n_out;

    // first level: select within groups of eight
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if ((g * GRP + k < NREAD) && (i_idx == IDX_W'(g * GRP + k))) begin
                    n_grp[g] = n_grp[g] | i_data[g * GRP + k];
                end
            end
        end
    end

    always_comb begin
        n_out = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_out = n_out | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_out <= n_out;
    end

    assign o_data = r_out;

endmodule

// ===== sv/indexed_insert_erase_list_unit.sv =====
// channel  dir  fields                                  transfer when
// i_cmd    in   command[1:0] index[5:0] value[31:0]     valid & ready
// o_res    out  read_value[31:0] element_count[6:0]     valid & ready
//               status[1:0]
//
// one command at a time; the result goes valid after the registered index
// and the two registered levels of the read select tree
// a new command is taken in the cycle its predecessor's result is transferred
// insert shifts cells above the index, erase those from it, on transfer
// synchronous active-low reset clears count and control, cells are not reset
// a stalled result holds, and no command is taken until it is transferred
module indexed_insert_erase_list_unit import iel_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    iel_cmd_if.sink   i_cmd,
    iel_res_if.source o_res
);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_idx;
    t_status          r_status;
    t_status          n_status;
    logic             r_rd_ok;

    logic       w_in_ready;
    logic       w_out_valid;
    logic       w_accept;
    t_cmd       w_cmd;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_cnt;
    t_cell_ctrl w_ctrl;
    t_elem      w_cells [CAPACITY];
    t_elem      w_read  [NREAD];
    t_elem      w_tree;
    logic [31:0] w_cnt_wide;

    assign w_cmd    = t_cmd'(i_cmd.command);
    assign w_idx    = CMP_W'(i_cmd.index);
    assign w_cnt    = CMP_W'(r_count);
    assign w_accept = i_cmd.valid && w_in_ready;

    always_comb begin
        n_status = STAT_OK;
        if (w_cmd == CMD_INS) begin
            if (w_idx > w_cnt) begin
                n_status = STAT_RANGE;
            end else if (r_count >= CNT_W'(CAPACITY)) begin
                n_status = STAT_FULL;
            end
        end else if (r_count == '0) begin
            n_status = STAT_EMPTY;
        end else if (w_idx >= w_cnt) begin
            n_status = STAT_RANGE;
        end
    end

    always_comb begin
        w_ctrl.ins = w_accept && (n_status == STAT_OK) && (w_cmd == CMD_INS);
        w_ctrl.era = w_accept && (n_status == STAT_OK) && (w_cmd == CMD_ERASE);
        w_ctrl.wr  = w_accept && (n_status == STAT_OK) && (w_cmd == CMD_WRITE);
        w_ctrl.idx = w_idx;
        w_ctrl.val = to_elem(i_cmd.value);
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.era) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            iel_cell u_cell (
                .i_clk   (i_clk),
                .i_pos   (CMP_W'(i)),
                .i_ctrl  (w_ctrl),
                .i_left  (w_cells[(i > 0) ? i - 1 : 0]),
                .i_right (w_cells[(i < CAPACITY - 1) ? i + 1 : i]),
                .o_data  (w_cells[i])
            );
        end
        for (genvar j = 0; j < NREAD; j++) begin : g_read
            assign w_read[j] = w_cells[j];
        end
    endgenerate

    iel_read_tree u_read_tree (
        .i_clk  (i_clk),
        .i_data (w_read),
        .i_idx  (r_idx),
        .o_data (w_tree)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_GATHER;
            S_GATHER: n_state = S_REDUCE;
            S_REDUCE: n_state = S_HOLD;
            S_HOLD: begin
                if (w_accept) begin
                    n_state = S_GATHER;
                end else if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_out_valid = 1'b0;
        case (r_state)
            S_IDLE: w_in_ready = 1'b1;
            S_HOLD: begin
                w_out_valid = 1'b1;
                w_in_ready  = o_res.ready;
            end
            default: begin
                w_in_ready  = 1'b0;
                w_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx    <= i_cmd.index;
            r_status <= n_status;
            r_rd_ok  <= (n_status == STAT_OK) && (w_cmd == CMD_READ);
        end
    end

    assign w_cnt_wide = 32'(r_count);

    assign i_cmd.ready         = w_in_ready;
    assign o_res.valid         = w_out_valid;
    assign o_res.read_value    = r_rd_ok ? from_elem(w_tree) : '0;
    assign o_res.element_count = w_cnt_wide[CNT_OUT_W-1:0];
    assign o_res.status        = r_status;

endmodule
